FILE: rtl/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared types, character codes and helper functions for the version string
// comparator.
// ----------------------------------------------------------------------------
`default_nettype none

package vsc_pkg;

	localparam int unsigned MAX_LEN_DEF = 255;
	localparam int LEN_W = 8;
	localparam int ORD_W = 9;
	localparam int CHAR_W = 8;
	localparam int RANK_W = 3;

	localparam logic [CHAR_W-1:0] CH_TILDE  = 8'd126;
	localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'd45;
	localparam logic [CHAR_W-1:0] CH_CARET  = 8'd94;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'd46;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'd58;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic signed [ORD_W-1:0] ord_t;

	localparam ord_t ORD_ONE     = 9'sd1;
	localparam ord_t ORD_NEG_ONE = -9'sd1;
	localparam ord_t ORD_ZERO    = 9'sd0;

	typedef enum logic [1:0] {
		REG_EPOCH,
		REG_DELIM_RANK,
		REG_REMAINDER,
		REG_DIGIT_RULE
	} reg_idx_t;

	// class of the first character of the longer string's remainder
	typedef enum logic [1:0] {
		REM_OTHER,
		REM_TILDE,
		REM_HYPHEN,
		REM_CARET
	} rem_t;

	typedef struct packed {
		logic epoch_en;
		logic delim_rank_en;
		logic remainder_en;
		logic digit_rule;
	} cfg_t;

	typedef struct packed {
		ord_t seg_diff;
		logic verdict_found;
		ord_t verdict;
		logic l_colon_seen;
		len_t l_colon_pos;
		logic r_colon_seen;
		len_t r_colon_pos;
		len_t l_count;
		len_t r_count;
		logic l_prev_digit;
		logic r_prev_digit;
		logic rem_found;
		rem_t rem;
	} cmp_state_t;

	function automatic logic [RANK_W-1:0] delim_rank(input logic [CHAR_W-1:0] c);
		logic [RANK_W-1:0] r;
		unique case (c)
			CH_TILDE:  r = 3'd1;
			CH_HYPHEN: r = 3'd2;
			CH_CARET:  r = 3'd3;
			CH_DOT:    r = 3'd4;
			CH_COLON:  r = 3'd5;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic rem_t rem_class(input logic [CHAR_W-1:0] c);
		rem_t r;
		unique case (c)
			CH_TILDE:  r = REM_TILDE;
			CH_HYPHEN: r = REM_HYPHEN;
			CH_CARET:  r = REM_CARET;
			default:   r = REM_OTHER;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/version_string_compare.sv
// ----------------------------------------------------------------------------
// version_string_compare
// Orders two version strings streamed side by side, one character pair per
// transaction, and returns a signed order on the final pair.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | note
//  s_axis   | in  | tdata: left_char, left_present, right_char,    | one pair
//           |     |        right_present; tlast: last              |
//  m_axis   | out | tdata: order (9 bit signed)                    | one per last
//  cfg      | in  | cfg_index selects register, cfg_data bit 0     | write only
//
// One pair is accepted per cycle. A last pair's order passes through the
// snapshot register, then through the order resolver into the output
// register. Reset clears the running state, the config register and both
// valid flags. A stalled output backs up into the snapshot register; input
// stalls only once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module version_string_compare import vsc_pkg::*; #(
	parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] left_char, [8] left_present, [16:9] right_char, [17] right_present
	input  logic [23:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [8:0] order
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);

	cfg_t       cfg_q;
	logic       snap_valid;
	logic       snap_take;
	cmp_state_t snap;
	ord_t       order;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EPOCH:      cfg_q.epoch_en      <= cfg_data;
				REG_DELIM_RANK: cfg_q.delim_rank_en <= cfg_data;
				REG_REMAINDER:  cfg_q.remainder_en  <= cfg_data;
				REG_DIGIT_RULE: cfg_q.digit_rule    <= cfg_data;
			endcase
		end
	end

	vsc_accum #(
		.MAX_LEN(MAX_LEN)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.left_char    (s_axis_tdata[7:0]),
		.left_present (s_axis_tdata[8]),
		.right_char   (s_axis_tdata[16:9]),
		.right_present(s_axis_tdata[17]),
		.last         (s_axis_tlast),
		.delim_rank_en(cfg_q.delim_rank_en),
		.snap_take    (snap_take),
		.snap_valid   (snap_valid),
		.snap         (snap)
	);

	vsc_order u_order (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.snap_valid(snap_valid),
		.snap      (snap),
		.snap_take (snap_take),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.order     (order)
	);

	assign m_axis_tdata = {7'd0, order};

endmodule

`default_nettype wire

FILE: rtl/vsc_accum.sv
// ----------------------------------------------------------------------------
// vsc_accum
// Running comparison state. Folds one character pair per transaction into the
// state and hands a snapshot to the order stage on the final pair.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_accum import vsc_pkg::*; #(
	parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] left_char,
	input  logic              left_present,
	input  logic [CHAR_W-1:0] right_char,
	input  logic              right_present,
	input  logic              last,
	input  logic              delim_rank_en,
	input  logic              snap_take,
	output logic              snap_valid,
	output cmp_state_t        snap
);

	cmp_state_t st_q;
	cmp_state_t nxt;
	len_t       pos_q;
	len_t       pos_nxt;
	logic       snap_valid_s1;
	cmp_state_t snap_s1;
	logic       accept;
	logic       ld, rd;
	ord_t       char_diff;
	ord_t       rank_diff;

	assign in_ready = !snap_valid_s1 || snap_take;
	assign accept   = in_valid && in_ready;

	assign ld        = delim_rank(left_char) != '0;
	assign rd        = delim_rank(right_char) != '0;
	assign char_diff = $signed({1'b0, left_char}) - $signed({1'b0, right_char});
	assign rank_diff = $signed({{(ORD_W-RANK_W){1'b0}}, delim_rank(left_char)})
		- $signed({{(ORD_W-RANK_W){1'b0}}, delim_rank(right_char)});

	always_comb begin
		nxt     = st_q;
		pos_nxt = pos_q;
		if (pos_q < LEN_W'(MAX_LEN)) begin
			pos_nxt = pos_q + 1'b1;
			if (left_present) begin
				if (left_char == CH_COLON && !st_q.l_colon_seen) begin
					nxt.l_colon_seen = 1'b1;
					nxt.l_colon_pos  = st_q.l_count;
				end
				nxt.l_count = st_q.l_count + 1'b1;
			end
			if (right_present) begin
				if (right_char == CH_COLON && !st_q.r_colon_seen) begin
					nxt.r_colon_seen = 1'b1;
					nxt.r_colon_pos  = st_q.r_count;
				end
				nxt.r_count = st_q.r_count + 1'b1;
			end
			if (left_present && right_present) begin
				if (!st_q.verdict_found) begin
					priority if (!ld && !rd) begin
						if (st_q.seg_diff == ORD_ZERO)
							nxt.seg_diff = char_diff;
					end else if (ld && !rd) begin
						nxt.verdict_found = 1'b1;
						nxt.verdict       = ORD_NEG_ONE;
					end else if (!ld && rd) begin
						nxt.verdict_found = 1'b1;
						nxt.verdict       = ORD_ONE;
					end else if (st_q.seg_diff != ORD_ZERO) begin
						nxt.verdict_found = 1'b1;
						nxt.verdict       = st_q.seg_diff;
					end else begin
						if (delim_rank_en && rank_diff != ORD_ZERO) begin
							nxt.verdict_found = 1'b1;
							nxt.verdict       = rank_diff;
						end
					end
				end
				nxt.l_prev_digit = is_digit(left_char);
				nxt.r_prev_digit = is_digit(right_char);
			end else if ((left_present || right_present) && !st_q.rem_found) begin
				nxt.rem_found = 1'b1;
				nxt.rem       = rem_class(left_present ? left_char : right_char);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= '0;
			pos_q         <= '0;
			snap_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (last) begin
					st_q  <= '0;
					pos_q <= '0;
				end else begin
					st_q  <= nxt;
					pos_q <= pos_nxt;
				end
			end
			if (accept && last)
				snap_valid_s1 <= 1'b1;
			else if (snap_take)
				snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last)
			snap_s1 <= nxt;
	end

	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;

endmodule

`default_nettype wire

FILE: rtl/vsc_order.sv
// ----------------------------------------------------------------------------
// vsc_order
// Resolves a finished comparison snapshot into the signed order and holds it
// in the output register until the transaction completes.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_order import vsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       snap_valid,
	input  cmp_state_t snap,
	output logic       snap_take,
	output logic       out_valid,
	input  logic       out_ready,
	output ord_t       order
);

	logic out_valid_q;
	ord_t order_q;
	ord_t colon_delta;
	ord_t len_diff;
	ord_t rem_res;
	ord_t res;
	logic rem_hit;
	logic l_short;
	logic prev_digit;
	rem_t rc;

	assign snap_take = snap_valid && (!out_valid_q || out_ready);

	always_comb begin
		colon_delta = ORD_ZERO;
		if (snap.l_colon_seen && snap.r_colon_seen)
			colon_delta = $signed({1'b0, snap.l_colon_pos}) - $signed({1'b0, snap.r_colon_pos});
		else if (snap.l_colon_seen)
			colon_delta = ORD_ONE;
		else if (snap.r_colon_seen)
			colon_delta = ORD_NEG_ONE;

		len_diff   = $signed({1'b0, snap.l_count}) - $signed({1'b0, snap.r_count});
		l_short    = snap.l_count < snap.r_count;
		prev_digit = l_short ? snap.l_prev_digit : snap.r_prev_digit;
		rc         = snap.rem_found ? snap.rem : REM_OTHER;

		unique case (rc)
			REM_TILDE: begin
				rem_hit = 1'b1;
				rem_res = l_short ? ORD_ONE : ORD_NEG_ONE;
			end
			REM_HYPHEN: begin
				rem_hit = 1'b1;
				rem_res = ORD_ZERO;
			end
			REM_CARET: begin
				rem_hit = 1'b1;
				rem_res = l_short ? ORD_NEG_ONE : ORD_ONE;
			end
			REM_OTHER: begin
				rem_hit = (snap.seg_diff != ORD_ZERO) && (!cfg.digit_rule || !prev_digit);
				rem_res = snap.seg_diff;
			end
		endcase

		priority if (cfg.epoch_en && colon_delta != ORD_ZERO)
			res = colon_delta;
		else if (snap.verdict_found)
			res = snap.verdict;
		else if (snap.l_count == snap.r_count)
			res = snap.seg_diff;
		else if (cfg.remainder_en && rem_hit)
			res = rem_res;
		else
			res = len_diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (snap_take)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (snap_take)
			order_q <= res;
	end

	assign out_valid = out_valid_q;
	assign order     = order_q;

endmodule

`default_nettype wire

FILE: rtl/vsc_checker.sv
// ----------------------------------------------------------------------------
// vsc_checker
// Port-level checks for the version string comparator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// order stays within +/-255 and padding is zero
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0 && m_axis_tdata[8:0] != 9'h100)
		else $error("order out of range");

	// input only backs up when the output is stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// a final pair accepted while no result is pending shows up as a result
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid |=> ##1 m_axis_tvalid)
		else $error("result missing after final pair");

endmodule

bind version_string_compare vsc_checker u_vsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
